### sv/dxtf_pkg.sv
package dxtf_pkg;

  localparam int unsigned MaxDimLog2Default = 12;
  localparam int unsigned DestW = 21;
  localparam int unsigned BlockW = 64;
  localparam int unsigned DimW = 4;
  localparam int unsigned LevelCntW = 4;
  localparam int unsigned FmtW = 2;
  localparam int unsigned BlockSideLog2 = 2;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidthLog2  = 4'd0,
    CfgHeightLog2 = 4'd1,
    CfgLevelCount = 4'd2,
    CfgFormat     = 4'd3
  } cfg_idx_e;

  typedef enum logic [FmtW-1:0] {
    FmtDxt1 = 2'd0,
    FmtDxt3 = 2'd1,
    FmtDxt5 = 2'd2,
    FmtRaw  = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    OpPass = 2'd0,
    OpHalf = 2'd1,
    OpFull = 2'd2
  } op_e;

  typedef struct packed {
    logic [DestW-1:0]  dest;
    logic              last;
    op_e               op;
    fmt_e              fmt;
    logic [BlockW-1:0] lo;
    logic [BlockW-1:0] hi;
  } entry_t;

endpackage

### sv/dxtf_if.sv
interface dxtf_in_if;
  logic                       valid;
  logic                       ready;
  logic [dxtf_pkg::BlockW-1:0] block_lo;
  logic [dxtf_pkg::BlockW-1:0] block_hi;

  modport source (output valid, output block_lo, output block_hi, input ready);
  modport sink (input valid, input block_lo, input block_hi, output ready);
endinterface

interface dxtf_out_if;
  logic                       valid;
  logic                       ready;
  logic [dxtf_pkg::DestW-1:0]  dest_block;
  logic [dxtf_pkg::BlockW-1:0] out_lo;
  logic [dxtf_pkg::BlockW-1:0] out_hi;
  logic                       last_block;

  modport source (output valid, output dest_block, output out_lo, output out_hi,
                  output last_block, input ready);
  modport sink (input valid, input dest_block, input out_lo, input out_hi,
                input last_block, output ready);
endinterface

interface dxtf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dxtf_pkg::CfgIdxW-1:0]  index;
  logic [dxtf_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/dxtf_front.sv
module dxtf_front #(
  parameter int unsigned MaxDimLog2 = dxtf_pkg::MaxDimLog2Default
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dxtf_in_if.sink          in_i,
  dxtf_cfg_if.sink         cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output dxtf_pkg::entry_t entry_o
);
  import dxtf_pkg::*;

  localparam int unsigned ColW = (MaxDimLog2 > BlockSideLog2) ? MaxDimLog2 - BlockSideLog2 : 1;
  localparam int unsigned LevelW = $clog2(MaxDimLog2 + 2);
  localparam int unsigned ShW = $clog2(2 * MaxDimLog2 + 1);
  localparam logic [DimW-1:0] MaxDim = DimW'(MaxDimLog2);
  localparam logic [LevelCntW:0] MaxLevels = (LevelCntW + 1)'(MaxDimLog2 + 1);

  logic [DimW-1:0]      width_q, height_q;
  logic [LevelCntW-1:0] level_count_q;
  fmt_e                 fmt_q;

  logic [LevelW-1:0] level_q;
  logic [ColW-1:0]   col_q, row_q;
  logic [DestW-1:0]  base_q;

  logic [DimW-1:0]   wl, hl, wd, hd, shw, shh;
  logic [ColW-1:0]   mask_c, mask_r, drow;
  logic              col_last, row_last, level_last;
  logic [LevelCntW:0] eff_levels, clamp_levels;
  logic [LevelW:0]   level_inc;
  logic              cfg_restart, accept;
  op_e               op;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign accept      = in_i.valid && !full_i;
  assign push_o      = accept;
  assign cfg_restart = cfg_i.valid && (cfg_i.index <= CfgFormat);

  always_comb begin
    wl = (width_q > MaxDim) ? MaxDim : width_q;
    hl = (height_q > MaxDim) ? MaxDim : height_q;
    wd = (wl > DimW'(level_q)) ? wl - DimW'(level_q) : '0;
    hd = (hl > DimW'(level_q)) ? hl - DimW'(level_q) : '0;
    shw = (wd > DimW'(BlockSideLog2)) ? wd - DimW'(BlockSideLog2) : '0;
    shh = (hd > DimW'(BlockSideLog2)) ? hd - DimW'(BlockSideLog2) : '0;
    mask_c = ColW'(((ColW + 1)'(1) << shw) - (ColW + 1)'(1));
    mask_r = ColW'(((ColW + 1)'(1) << shh) - (ColW + 1)'(1));
    col_last = (col_q == mask_c);
    row_last = (row_q == mask_r);
    clamp_levels = ({1'b0, level_count_q} > MaxLevels) ? MaxLevels : {1'b0, level_count_q};
    eff_levels = (level_count_q == '0) ? (LevelCntW + 1)'(1) : clamp_levels;
    level_inc = {1'b0, level_q} + (LevelW + 1)'(1);
    level_last = ((LevelCntW + 1)'(level_inc) >= eff_levels);

    if (fmt_q == FmtRaw) begin
      op = OpPass;
    end else if (hd == DimW'(1)) begin
      op = OpHalf;
    end else if (hd >= DimW'(2)) begin
      op = OpFull;
    end else begin
      op = OpPass;
    end
    drow = (op == OpFull) ? mask_r - row_q : row_q;

    entry_o.dest = base_q + (DestW'(drow) << shw) + DestW'(col_q);
    entry_o.last = col_last && row_last && level_last;
    entry_o.op   = op;
    entry_o.fmt  = fmt_q;
    entry_o.lo   = in_i.block_lo;
    entry_o.hi   = in_i.block_hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= '0;
      height_q      <= '0;
      level_count_q <= LevelCntW'(1);
      fmt_q         <= FmtDxt1;
      level_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      base_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgWidthLog2:  width_q       <= cfg_i.data[DimW-1:0];
          CfgHeightLog2: height_q      <= cfg_i.data[DimW-1:0];
          CfgLevelCount: level_count_q <= cfg_i.data[LevelCntW-1:0];
          CfgFormat:     fmt_q         <= fmt_e'(cfg_i.data[FmtW-1:0]);
          default: ;
        endcase
      end
      if (cfg_restart) begin
        level_q <= '0;
        col_q   <= '0;
        row_q   <= '0;
        base_q  <= '0;
      end else if (accept) begin
        if (!col_last) begin
          col_q <= col_q + ColW'(1);
        end else begin
          col_q <= '0;
          if (!row_last) begin
            row_q <= row_q + ColW'(1);
          end else begin
            row_q <= '0;
            if (level_last) begin
              level_q <= '0;
              base_q  <= '0;
            end else begin
              level_q <= LevelW'(level_inc);
              base_q  <= base_q + (DestW'(1) << (ShW'(shw) + ShW'(shh)));
            end
          end
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_i.valid && entry_o.last) |=> (level_q == '0 && col_q == '0 && row_q == '0))
    else $error("walk did not wrap after the last block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= mask_c) && (row_q <= mask_r))
    else $error("block position outside the current level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> (base_q == '0 && level_q == '0))
    else $error("register write did not restart the walk");

endmodule

### sv/dxtf_queue.sv
module dxtf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dxtf_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output dxtf_pkg::entry_t entry_o,
  output logic             empty_o
);
  import dxtf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a push");

endmodule

### sv/dxtf_back.sv
module dxtf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dxtf_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  dxtf_out_if.source       out_o
);
  import dxtf_pkg::*;

  logic              valid_q;
  logic [DestW-1:0]  dest_q;
  logic [BlockW-1:0] lo_q, hi_q, lo_d, hi_d;
  logic              last_q;

  function automatic logic [BlockW-1:0] color_full(input logic [BlockW-1:0] x);
    return {x[39:32], x[47:40], x[55:48], x[63:56], x[31:0]};
  endfunction

  function automatic logic [BlockW-1:0] color_half(input logic [BlockW-1:0] x);
    return {x[63:48], x[39:32], x[47:40], x[31:0]};
  endfunction

  function automatic logic [BlockW-1:0] alpha4_full(input logic [BlockW-1:0] x);
    return {x[15:0], x[31:16], x[47:32], x[63:48]};
  endfunction

  function automatic logic [BlockW-1:0] alpha4_half(input logic [BlockW-1:0] x);
    return {x[63:32], x[15:0], x[31:16]};
  endfunction

  function automatic logic [BlockW-1:0] alpha3_full(input logic [BlockW-1:0] x);
    return {x[27:16], x[39:28], x[51:40], x[63:52], x[15:0]};
  endfunction

  function automatic logic [BlockW-1:0] alpha3_half(input logic [BlockW-1:0] x);
    return {x[63:40], x[27:16], x[39:28], x[15:0]};
  endfunction

  assign pop_o            = !empty_i && (!valid_q || out_o.ready);
  assign out_o.valid      = valid_q;
  assign out_o.dest_block = dest_q;
  assign out_o.out_lo     = lo_q;
  assign out_o.out_hi     = hi_q;
  assign out_o.last_block = last_q;

  always_comb begin
    lo_d = entry_i.lo;
    hi_d = entry_i.hi;
    case (entry_i.op)
      OpHalf: begin
        if (entry_i.fmt == FmtDxt1) begin
          lo_d = color_half(entry_i.lo);
        end else begin
          lo_d = (entry_i.fmt == FmtDxt3) ? alpha4_half(entry_i.lo) : alpha3_half(entry_i.lo);
          hi_d = color_half(entry_i.hi);
        end
      end
      OpFull: begin
        if (entry_i.fmt == FmtDxt1) begin
          lo_d = color_full(entry_i.lo);
        end else begin
          lo_d = (entry_i.fmt == FmtDxt3) ? alpha4_full(entry_i.lo) : alpha3_full(entry_i.lo);
          hi_d = color_full(entry_i.hi);
        end
      end
      default: ;
    endcase
    if (entry_i.fmt == FmtDxt1) begin
      hi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dest_q <= entry_i.dest;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      last_q <= entry_i.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("result register not loaded after a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |-> !pop_o)
    else $error("held result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_i && !valid_q) |=> !valid_q)
    else $error("result appeared without a queued block");

endmodule

### sv/dxtc_image_vertical_flip_core.sv
// Vertical flip of DXT1, DXT3 and DXT5 blocks over a mip chain: each block
// request comes out with its lines mirrored and with its destination index,
// so that block rows are reversed within each level; levels two texels high
// only exchange their first two lines, and levels one texel high pass
// through, as do raw blocks. The block takes one request per cycle and gives
// one result per cycle when neither side stalls; each block is held in the
// queue, then the output register. Walker counters step per accepted block,
// and a two-entry queue plus the output register let input and output stall
// independently. Any register write restarts the walk at the first block.
module dxtc_image_vertical_flip_core #(
  parameter int unsigned MaxDimLog2 = dxtf_pkg::MaxDimLog2Default
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dxtf_in_if.sink    in_i,
  dxtf_cfg_if.sink   cfg_i,
  dxtf_out_if.source out_o
);
  import dxtf_pkg::*;

  logic   push, full, pop, empty;
  entry_t front_entry, back_entry;

  dxtf_front #(
    .MaxDimLog2(MaxDimLog2)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .entry_o(front_entry)
  );

  dxtf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(back_entry),
    .empty_o(empty)
  );

  dxtf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .entry_i(back_entry),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
